// ----- hdl/ght_pkg.sv -----
// shared constants, types and helper functions for the generational handle table
`timescale 1ns / 1ps

package ght_pkg;

   localparam int SLOT_COUNT = 512;

   // handle layout
   localparam int FIELD_W   = 16;
   localparam int HANDLE_W  = 32;
   localparam int DATA_W    = 32;

   // active bits are kept in rows of 32 in a memory, one valid and one full bit per row
   localparam int ROW_WIDTH  = 32;
   localparam int BIT_W      = $clog2(ROW_WIDTH);
   localparam int ROWS       = (SLOT_COUNT + ROW_WIDTH - 1) / ROW_WIDTH;
   localparam int ROW_IDX_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int SLOT_IDX_W = ROW_IDX_W + BIT_W;
   localparam int SLOT_DEPTH = ROWS * ROW_WIDTH;

   typedef enum logic [1:0] {
      OP_ALLOC  = 2'd0,
      OP_LOOKUP = 2'd1,
      OP_FREE   = 2'd2,
      OP_NONE   = 2'd3
   } opcode_type;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   typedef struct packed {
      logic [FIELD_W-1:0] generation;
      logic [DATA_W-1:0]  surface;
      logic [DATA_W-1:0]  owner;
   } slot_entry_type;

   // bits of a row that lie past the last slot read as permanently active
   function automatic logic [ROW_WIDTH-1:0] row_pad(input logic [ROW_IDX_W-1:0] row);
      logic [ROW_WIDTH-1:0] pad;
      pad = '0;
      for (int b = 0; b < ROW_WIDTH; b++) begin
         pad[b] = ((int'(row) * ROW_WIDTH + b) >= SLOT_COUNT);
      end
      return pad;
   endfunction

endpackage

// ----- hdl/ght_if.sv -----
// request and response channel interfaces of the generational handle table
`timescale 1ns / 1ps

interface ght_req_if;
   import ght_pkg::*;

   logic                valid;
   logic                ready;
   logic [1:0]          opcode;
   logic [HANDLE_W-1:0] handle;
   logic [DATA_W-1:0]   surface_tag;
   logic [DATA_W-1:0]   owner_tag;

   modport source (output valid, output opcode, output handle, output surface_tag,
                   output owner_tag, input ready);
   modport sink   (input valid, input opcode, input handle, input surface_tag,
                   input owner_tag, output ready);
endinterface

interface ght_rsp_if;
   import ght_pkg::*;

   logic                valid;
   logic                ready;
   logic                ok;
   logic [HANDLE_W-1:0] new_handle;
   logic [DATA_W-1:0]   found_surface;
   logic [DATA_W-1:0]   found_owner;

   modport source (output valid, output ok, output new_handle, output found_surface,
                   output found_owner, input ready);
   modport sink   (input valid, input ok, input new_handle, input found_surface,
                   input found_owner, output ready);
endinterface

// ----- hdl/generational_handle_table.sv -----
// top level of the generational handle table: slot memories and request sequencer
`timescale 1ns / 1ps

// Generational handle table. In the accept cycle a request issues the synchronous
// reads of the active-bit row memory and the slot memory; in the execute state the
// table checks the slot, writes both memories back and loads the response register.
// The response waits in an output register, so the next request is accepted while it
// is pending; the execute state holds only while a previous response has not been
// taken. Allocate picks the lowest row that is not full from per-row full flags, then
// the lowest free bit in that row. Per-row valid flags are cleared by reset, so the
// block is usable at once: no clearing pass follows reset. Slot data is undefined
// until an allocate writes it.
module generational_handle_table (
   input logic        clock,
   input logic        reset,
   ght_req_if.sink    req_ch,
   ght_rsp_if.source  rsp_ch
);
   import ght_pkg::*;

   // memories
   logic [ROW_WIDTH-1:0] active_mem [ROWS];
   slot_entry_type       slot_mem   [SLOT_DEPTH];

   // control state
   state_type             state_ff, state_in;
   logic [ROWS-1:0]       row_valid_ff, row_valid_in;
   logic [ROWS-1:0]       full_ff, full_in;
   logic [FIELD_W-1:0]    next_gen_ff, next_gen_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // latched request
   logic [1:0]            op_ff;
   logic                  fail_ff, fail_in;
   logic [FIELD_W-1:0]    hgen_ff;
   logic [SLOT_IDX_W-1:0] slot_ff, slot_in;
   logic [ROW_IDX_W-1:0]  row_ff, row_in;
   logic [DATA_W-1:0]     surface_ff;
   logic [DATA_W-1:0]     owner_ff;

   // memory read data
   logic [ROW_WIDTH-1:0]  active_rd_ff;
   slot_entry_type        slot_rd_ff;

   // response payload
   logic                  ok_ff, ok_in;
   logic [HANDLE_W-1:0]   new_handle_ff, new_handle_in;
   logic [DATA_W-1:0]     found_surface_ff, found_surface_in;
   logic [DATA_W-1:0]     found_owner_ff, found_owner_in;

   logic                  accept;
   logic                  finish;
   logic                  can_finish;

   // accept-side decode
   logic [FIELD_W-1:0]    handle_slot;
   logic                  in_range;
   logic                  have_free_row;
   logic [ROW_IDX_W-1:0]  free_row;

   // execute-side datapath
   logic [ROW_WIDTH-1:0]  eff_word;
   logic                  have_free_bit;
   logic [BIT_W-1:0]      free_bit;
   logic [BIT_W-1:0]      sel_bit;
   logic [ROW_WIDTH-1:0]  bit_mask;
   logic [ROW_WIDTH-1:0]  new_word;
   logic                  match;
   logic [FIELD_W-1:0]    alloc_gen;
   logic [SLOT_IDX_W-1:0] alloc_slot;
   logic                  act_we;
   logic                  slot_we;

   // lowest row that still has an inactive slot
   always_comb begin
      have_free_row = 1'b0;
      free_row      = '0;
      for (int r = ROWS - 1; r >= 0; r--) begin
         if (!full_ff[r]) begin
            have_free_row = 1'b1;
            free_row      = ROW_IDX_W'(r);
         end
      end
   end

   assign handle_slot = req_ch.handle[FIELD_W-1:0];
   assign in_range    = ({1'b0, handle_slot} < (FIELD_W + 1)'(SLOT_COUNT));

   // request latch decode
   always_comb begin
      slot_in = handle_slot[SLOT_IDX_W-1:0];
      row_in  = slot_in[SLOT_IDX_W-1:BIT_W];
      case (req_ch.opcode)
         OP_ALLOC: begin
            fail_in = !have_free_row;
            row_in  = free_row;
         end
         OP_LOOKUP, OP_FREE: fail_in = !in_range;
         default:            fail_in = 1'b1;
      endcase
   end

   // request sequencer
   assign can_finish = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      state_in     = state_ff;
      req_ch.ready = 1'b0;
      finish       = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ch.ready = 1'b1;
            if (req_ch.valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (can_finish) begin
               finish   = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign accept = req_ch.valid && req_ch.ready;

   // active row as seen after reset and padding
   assign eff_word = (row_valid_ff[row_ff] ? active_rd_ff : '0) | row_pad(row_ff);

   // lowest inactive bit in the row
   always_comb begin
      have_free_bit = 1'b0;
      free_bit      = '0;
      for (int b = ROW_WIDTH - 1; b >= 0; b--) begin
         if (!eff_word[b]) begin
            have_free_bit = 1'b1;
            free_bit      = BIT_W'(b);
         end
      end
   end

   assign sel_bit    = (op_ff == OP_ALLOC) ? free_bit : slot_ff[BIT_W-1:0];
   assign bit_mask   = ROW_WIDTH'(1) << sel_bit;
   assign match      = !fail_ff && eff_word[sel_bit] && (slot_rd_ff.generation == hgen_ff);
   assign alloc_gen  = (next_gen_ff == '0) ? FIELD_W'(1) : next_gen_ff;
   assign alloc_slot = {row_ff, free_bit};

   // read-modify-write and response
   always_comb begin
      act_we           = 1'b0;
      slot_we          = 1'b0;
      new_word         = eff_word;
      row_valid_in     = row_valid_ff;
      full_in          = full_ff;
      next_gen_in      = next_gen_ff;
      ok_in            = 1'b0;
      new_handle_in    = '0;
      found_surface_in = '0;
      found_owner_in   = '0;
      case (op_ff)
         OP_ALLOC: begin
            if (!fail_ff && have_free_bit) begin
               act_we        = finish;
               slot_we       = finish;
               new_word      = eff_word | bit_mask;
               ok_in         = 1'b1;
               new_handle_in = {alloc_gen, FIELD_W'(alloc_slot)};
               next_gen_in   = alloc_gen + FIELD_W'(1);
            end
         end
         OP_LOOKUP: begin
            if (match) begin
               ok_in            = 1'b1;
               found_surface_in = slot_rd_ff.surface;
               found_owner_in   = slot_rd_ff.owner;
            end
         end
         OP_FREE: begin
            if (match) begin
               act_we   = finish;
               new_word = eff_word & ~bit_mask;
               ok_in    = 1'b1;
            end
         end
         default: ;
      endcase
      if (act_we) begin
         row_valid_in[row_ff] = 1'b1;
         full_in[row_ff]      = &new_word;
      end
      if (!slot_we) begin
         next_gen_in = next_gen_ff;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (finish) begin
         rsp_valid_in = 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         row_valid_ff <= '0;
         full_ff      <= '0;
         next_gen_ff  <= FIELD_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_valid_ff <= row_valid_in;
         full_ff      <= full_in;
         next_gen_ff  <= next_gen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // request latch and response payload
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff      <= req_ch.opcode;
         fail_ff    <= fail_in;
         hgen_ff    <= req_ch.handle[HANDLE_W-1:FIELD_W];
         slot_ff    <= slot_in;
         row_ff     <= row_in;
         surface_ff <= req_ch.surface_tag;
         owner_ff   <= req_ch.owner_tag;
      end
      if (finish) begin
         ok_ff            <= ok_in;
         new_handle_ff    <= new_handle_in;
         found_surface_ff <= found_surface_in;
         found_owner_ff   <= found_owner_in;
      end
   end

   // active-bit row memory
   always_ff @(posedge clock) begin
      if (act_we) begin
         active_mem[row_ff] <= new_word;
      end
      if (accept) begin
         active_rd_ff <= active_mem[row_in];
      end
   end

   // slot data memory
   always_ff @(posedge clock) begin
      if (slot_we) begin
         slot_mem[alloc_slot] <= '{generation: alloc_gen, surface: surface_ff,
                                   owner: owner_ff};
      end
      if (accept) begin
         slot_rd_ff <= slot_mem[slot_in];
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.ok            = ok_ff;
   assign rsp_ch.new_handle    = new_handle_ff;
   assign rsp_ch.found_surface = found_surface_ff;
   assign rsp_ch.found_owner   = found_owner_ff;

endmodule

// ----- dv/generational_handle_table_test.sv -----
// self-checking testbench for the generational handle table: slot map mirror and stimulus
`timescale 1ns / 1ps

package ght_test_pkg;
   import ght_pkg::*;

   typedef struct packed {
      logic                ok;
      logic [HANDLE_W-1:0] new_handle;
      logic [DATA_W-1:0]   found_surface;
      logic [DATA_W-1:0]   found_owner;
   } table_rsp_type;

   // mirror of the slot map: predicts each response and checks the ones that come back
   class handle_table_mirror;
      bit                 slot_live    [SLOT_COUNT];
      logic [FIELD_W-1:0] slot_gen     [SLOT_COUNT];
      logic [DATA_W-1:0]  slot_surface [SLOT_COUNT];
      logic [DATA_W-1:0]  slot_owner   [SLOT_COUNT];
      logic [FIELD_W-1:0] gen_counter = 1;
      table_rsp_type      awaited [$];
      int unsigned        mismatches = 0;
      int unsigned        responses = 0;
      int unsigned        op_seen [4];
      int unsigned        op_ok   [4];

      // slot named by a handle if it is in range, active and of the same generation
      function int matching_slot(logic [HANDLE_W-1:0] h);
         int slot;
         slot = int'(h[FIELD_W-1:0]);
         if (slot >= SLOT_COUNT) return -1;
         if (!slot_live[slot]) return -1;
         if (slot_gen[slot] != h[HANDLE_W-1:FIELD_W]) return -1;
         return slot;
      endfunction

      function table_rsp_type note_request(opcode_type op, logic [HANDLE_W-1:0] h,
                                           logic [DATA_W-1:0] surf, logic [DATA_W-1:0] own);
         table_rsp_type      rsp;
         int                 slot;
         logic [FIELD_W-1:0] gen;
         rsp  = '0;
         slot = -1;
         case (op)
            OP_ALLOC: begin
               for (int i = 0; i < SLOT_COUNT; i++) begin
                  if (!slot_live[i] && slot < 0) slot = i;
               end
               if (slot >= 0) begin
                  gen = (gen_counter == '0) ? FIELD_W'(1) : gen_counter;
                  gen_counter = gen + 1'b1;
                  slot_live[slot]    = 1'b1;
                  slot_gen[slot]     = gen;
                  slot_surface[slot] = surf;
                  slot_owner[slot]   = own;
                  rsp.ok         = 1'b1;
                  rsp.new_handle = {gen, FIELD_W'(slot)};
               end
            end
            OP_LOOKUP: begin
               slot = matching_slot(h);
               if (slot >= 0) begin
                  rsp.ok            = 1'b1;
                  rsp.found_surface = slot_surface[slot];
                  rsp.found_owner   = slot_owner[slot];
               end
            end
            OP_FREE: begin
               slot = matching_slot(h);
               if (slot >= 0) begin
                  slot_live[slot] = 1'b0;
                  rsp.ok          = 1'b1;
               end
            end
            default: begin
            end
         endcase
         op_seen[op]++;
         if (rsp.ok) op_ok[op]++;
         awaited.push_back(rsp);
         return rsp;
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
         end
      endfunction

      function void check_response(table_rsp_type got);
         table_rsp_type want;
         responses++;
         if (awaited.size() == 0) begin
            mismatches++;
            $display("%0t: response with no request pending, expected none, got %h",
                     $time, got);
            return;
         end
         want = awaited.pop_front();
         compare_field("ok", 32'(want.ok), 32'(got.ok));
         compare_field("new_handle", want.new_handle, got.new_handle);
         compare_field("found_surface", want.found_surface, got.found_surface);
         compare_field("found_owner", want.found_owner, got.found_owner);
      endfunction
   endclass

endpackage

module generational_handle_table_test;
   import ght_pkg::*;
   import ght_test_pkg::*;

   localparam int HALF_PERIOD     = 4;
   localparam int RESET_CYCLES    = 12;
   localparam int RANDOM_REQUESTS = 320;
   localparam int STEADY_REQUESTS = 110;
   localparam int IDLE_PERCENT    = 22;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int HOLD_OFF_AFTER  = 150;
   localparam int RETIRED_KEEP    = 64;
   localparam int SETTLE_CYCLES   = 8;
   // about 450 requests plus one long hold-off, with wide margin
   localparam int unsigned CYCLE_LIMIT = 20_000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ght_req_if req_ch ();
   ght_rsp_if rsp_ch ();

   generational_handle_table DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always #HALF_PERIOD clock = ~clock;

   handle_table_mirror  book = new;
   table_rsp_type       last_rsp;
   logic [HANDLE_W-1:0] live_handles [$];     // handles the table should still honor
   logic [HANDLE_W-1:0] retired_handles [$];  // recently freed handles, now stale
   bit                  steady = 1'b0;        // both sides stop idling while set
   bit                  held_off = 1'b0;
   int unsigned         cycle_count = 0;

   // response side: random back-pressure, plus one long hold-off so the table stalls
   initial begin
      int unsigned hold_left;
      hold_left = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (!held_off && book.responses >= HOLD_OFF_AFTER) begin
            held_off  = 1'b1;
            hold_left = HOLD_OFF_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
         end
      end
   end

   // sample accepted responses at the rising edge and count cycles for the watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
         book.check_response({rsp_ch.ok, rsp_ch.new_handle, rsp_ch.found_surface,
                              rsp_ch.found_owner});
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("%0t: watchdog expired after %0d cycles", $time, cycle_count);
      $display("generational_handle_table verification failed");
      $finish;
   end

   // data words lean on the all-zero and all-one extremes now and then
   function automatic logic [DATA_W-1:0] pick_word();
      case ($urandom_range(9))
         0:       return '0;
         1:       return '1;
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [HANDLE_W-1:0] pick_live();
      return live_handles[$urandom_range(live_handles.size() - 1)];
   endfunction

   // offer one request, hold it until taken, then predict and track live handles
   task automatic send_request(input opcode_type op, input logic [HANDLE_W-1:0] h,
                               input logic [DATA_W-1:0] surf, input logic [DATA_W-1:0] own);
      int hit;
      @(negedge clock);
      while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.opcode      <= op;
      req_ch.handle      <= h;
      req_ch.surface_tag <= surf;
      req_ch.owner_tag   <= own;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      last_rsp = book.note_request(op, h, surf, own);
      if (last_rsp.ok && op == OP_ALLOC) begin
         live_handles.push_back(last_rsp.new_handle);
      end else if (last_rsp.ok && op == OP_FREE) begin
         hit = -1;
         foreach (live_handles[i]) begin
            if (hit < 0 && live_handles[i] == h) hit = i;
         end
         if (hit >= 0) live_handles.delete(hit);
         retired_handles.push_back(h);
         if (retired_handles.size() > RETIRED_KEEP) void'(retired_handles.pop_front());
      end
   endtask

   // lower valid and wait until every pending response has been taken
   task automatic rest_until_drained();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (book.awaited.size() != 0) @(posedge clock);
   endtask

   // malformed or pointless requests: stale, wrong generation, out of range, no-op
   task automatic send_noise();
      opcode_type          op;
      logic [HANDLE_W-1:0] h;
      op = $urandom_range(1) ? OP_LOOKUP : OP_FREE;
      h  = $urandom();
      case ($urandom_range(5))
         0: op = OP_NONE;
         1: begin
         end
         2: if (retired_handles.size() != 0)
               h = retired_handles[$urandom_range(retired_handles.size() - 1)];
         3: if (live_handles.size() != 0)
               h = pick_live() ^ (32'h1 << (FIELD_W + $urandom_range(FIELD_W - 1)));
         4: h = {FIELD_W'($urandom()), FIELD_W'($urandom_range(65535, SLOT_COUNT))};
         default: h = {FIELD_W'(0), FIELD_W'($urandom_range(SLOT_COUNT - 1))};
      endcase
      send_request(op, h, pick_word(), pick_word());
   endtask

   // mostly well-formed traffic on live handles, a fifth of it noise
   task automatic run_mix(input int count);
      int r;
      repeat (count) begin
         r = $urandom_range(99);
         if (r < 35 || (live_handles.size() == 0 && r < 80))
            send_request(OP_ALLOC, $urandom(), pick_word(), pick_word());
         else if (r < 60)
            send_request(OP_LOOKUP, pick_live(), pick_word(), pick_word());
         else if (r < 80)
            send_request(OP_FREE, pick_live(), pick_word(), pick_word());
         else
            send_noise();
      end
   endtask

   initial begin
      logic [HANDLE_W-1:0] h_a, h_b, h_c, h_d;

      req_ch.valid       = 1'b0;
      req_ch.opcode      = OP_NONE;
      req_ch.handle      = '0;
      req_ch.surface_tag = '0;
      req_ch.owner_tag   = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty table, extremes of the data, rejected handles of every kind
      send_request(OP_LOOKUP, '0, '0, '0);                 // all-zero handle
      send_request(OP_NONE, '1, '1, '1);                   // unused opcode
      send_request(OP_ALLOC, '1, '1, '1);
      h_a = last_rsp.new_handle;
      send_request(OP_ALLOC, '0, '0, '0);
      h_b = last_rsp.new_handle;
      send_request(OP_ALLOC, '0, 32'hA5A5_5A5A, 32'h0123_4567);
      h_c = last_rsp.new_handle;
      send_request(OP_LOOKUP, h_a, '0, '0);
      send_request(OP_LOOKUP, h_b, '1, '1);
      send_request(OP_LOOKUP, {FIELD_W'(0), h_a[FIELD_W-1:0]}, '0, '0);  // generation zero
      send_request(OP_LOOKUP, h_a ^ 32'h8000_0000, '0, '0);             // wrong generation
      send_request(OP_LOOKUP, {h_a[HANDLE_W-1:FIELD_W], FIELD_W'(SLOT_COUNT)}, '0, '0);
      send_request(OP_FREE, 32'h0001_FFFF, '0, '0);        // all-one slot field, out of range
      send_request(OP_FREE, '1, '0, '0);
      send_request(OP_FREE, h_b, '0, '0);
      send_request(OP_LOOKUP, h_b, '0, '0);                // inactive slot
      send_request(OP_FREE, h_b, '0, '0);                  // double free
      send_request(OP_ALLOC, '0, 32'hDEAD_BEEF, 32'h0000_0001);  // reuses the lowest free slot, the one h_b held
      h_d = last_rsp.new_handle;
      send_request(OP_LOOKUP, h_b, '0, '0);                // stale on a reused slot
      send_request(OP_LOOKUP, h_d, '0, '0);
      send_request(OP_NONE, '0, '0, '0);
      send_request(OP_FREE, h_a, '0, '0);
      send_request(OP_FREE, h_c, '0, '0);
      send_request(OP_FREE, h_d, '0, '0);
      rest_until_drained();

      // random mix; the response side's long hold-off lands in here
      run_mix(RANDOM_REQUESTS);
      rest_until_drained();

      // a long stretch with no idling on either side
      steady = 1'b1;
      run_mix(STEADY_REQUESTS);
      steady = 1'b0;
      rest_until_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("covered %0d allocates (%0d granted), %0d lookups (%0d hits),",
               book.op_seen[OP_ALLOC], book.op_ok[OP_ALLOC], book.op_seen[OP_LOOKUP],
               book.op_ok[OP_LOOKUP]);
      $display("%0d frees (%0d granted), %0d no-ops; %0d responses checked, %0d mismatches",
               book.op_seen[OP_FREE], book.op_ok[OP_FREE], book.op_seen[OP_NONE],
               book.responses, book.mismatches);
      if (book.mismatches == 0 && book.awaited.size() == 0) begin
         $display("generational_handle_table verification clean");
      end else begin
         $display("generational_handle_table verification failed");
      end
      $finish;
   end

endmodule
